// ===== sv/toroidal_life_generation_step_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the toroidal life generation step core
// Concurrent property wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef TOROIDAL_LIFE_GENERATION_STEP_CORE_ASSERT_SVH
`define TOROIDAL_LIFE_GENERATION_STEP_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TLG_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlg assertion failed");

// next-cycle implication, disabled during reset
`define TLG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlg assertion failed");

`endif

// ===== sv/tlg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlg_pkg
// Types and constants of the toroidal life generation step core.
// ----------------------------------------------------------------------------
package tlg_pkg;

   // beat field widths
   localparam int OP_W    = 2;
   localparam int ROW_W   = 6;
   localparam int COL_W   = 6;
   localparam int REQ_D_W = 16;  // row, column, cell_value, zero padding
   localparam int RSP_D_W = 8;   // read_value, zero padding

   // opcodes, echoed in the result kind
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

   // B3/S23 neighbour counts
   localparam int              NBR_W      = 4;
   localparam logic [NBR_W-1:0] NBR_BIRTH = 4'd3;
   localparam logic [NBR_W-1:0] NBR_KEEP  = 4'd2;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CELL = 4'b0010,
      ST_STEP = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

endpackage

// ===== sv/tlg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlg_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tlg_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/tlg_row_rule.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlg_row_rule
// Next generation of one row from the old rows above, at and below it.
// ----------------------------------------------------------------------------
module tlg_row_rule #(
   parameter int GRID_SIZE = 64
) (
   input  logic [GRID_SIZE-1:0] above,
   input  logic [GRID_SIZE-1:0] mid,
   input  logic [GRID_SIZE-1:0] below,
   output logic [GRID_SIZE-1:0] next_row
);
   import tlg_pkg::*;

   // one counter per column, columns wrap round the torus
   for (genvar c = 0; c < GRID_SIZE; c++) begin : g_col
      localparam int L = (c + GRID_SIZE - 1) % GRID_SIZE;
      localparam int R = (c + 1) % GRID_SIZE;
      logic [NBR_W-1:0] nbr;

      assign nbr = {3'b000, above[L]} + {3'b000, above[c]} + {3'b000, above[R]}
                 + {3'b000, mid[L]}                        + {3'b000, mid[R]}
                 + {3'b000, below[L]} + {3'b000, below[c]} + {3'b000, below[R]};

      assign next_row[c] = (nbr == NBR_BIRTH) || (mid[c] && (nbr == NBR_KEEP));
   end

endmodule

// ===== sv/toroidal_life_generation_step_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toroidal_life_generation_step_core
// B3/S23 life on a wrapping square grid held one row per RAM word.
// ----------------------------------------------------------------------------
//  channel  direction  tdata                            tuser
//  req_     in         [5:0] row [11:6] column [12] val [1:0] opcode
//  rsp_     out        [0] read_value                   [1:0] done_kind
//
//  Cell write or read: row read on accept, modify in ST_CELL, result beat from ST_DONE.
//  Generation step: one row per cycle through the single read port of the
//  row RAM, old first row kept aside for the wrap.
//  Reset clears a valid bit per row; unwritten rows read dead.
//  A stalled result holds in the output register; one more item is accepted
//  and finished, and then waits until the register frees.
// ----------------------------------------------------------------------------
module toroidal_life_generation_step_core #(
   parameter int GRID_SIZE = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [tlg_pkg::REQ_D_W-1:0]  req_tdata,   // row, column, cell_value
   input  logic [tlg_pkg::OP_W-1:0]     req_tuser,   // opcode
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [tlg_pkg::RSP_D_W-1:0]  rsp_tdata,   // read_value
   output logic [tlg_pkg::OP_W-1:0]     rsp_tuser    // done_kind
);
   import tlg_pkg::*;

   localparam int IW = $clog2(GRID_SIZE);
   localparam int CW = $clog2(GRID_SIZE + 2);
   localparam logic [CW-1:0]    CNT_ROWS = CW'(GRID_SIZE);
   localparam logic [CW-1:0]    CNT_LAST = CW'(GRID_SIZE + 1);
   localparam logic [ROW_W:0]   GRID_LIM = (ROW_W + 1)'(GRID_SIZE);
   localparam logic [IW-1:0]    ROW_TOP  = IW'(GRID_SIZE - 1);

   // request fields
   logic [OP_W-1:0]  req_op;
   logic [ROW_W-1:0] req_row;
   logic [COL_W-1:0] req_col;
   logic             req_val;
   logic             req_inside;
   logic             req_fire;

   assign req_op     = req_tuser;
   assign req_row    = req_tdata[ROW_W-1:0];
   assign req_col    = req_tdata[ROW_W+COL_W-1:ROW_W];
   assign req_val    = req_tdata[ROW_W+COL_W];
   assign req_inside = ({1'b0, req_row} < GRID_LIM) && ({1'b0, req_col} < GRID_LIM);

   // registers
   state_type          state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [IW-1:0]      row_ff, row_in;
   logic [IW-1:0]      col_ff, col_in;
   logic               val_ff, val_in;
   logic               inside_ff, inside_in;
   logic [GRID_SIZE-1:0] above_ff, above_in;
   logic [GRID_SIZE-1:0] mid_ff, mid_in;
   logic [GRID_SIZE-1:0] row0_ff, row0_in;
   logic [IW-1:0]      rd_addr_ff, rd_addr_in;
   logic [GRID_SIZE-1:0] valid_ff, valid_in;
   logic               res_read_ff, res_read_in;
   logic [OP_W-1:0]    res_kind_ff, res_kind_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_read_ff, rsp_read_in;
   logic [OP_W-1:0]    rsp_kind_ff, rsp_kind_in;

   // RAM side
   logic                 ram_wr_en;
   logic [IW-1:0]        ram_wr_addr;
   logic [GRID_SIZE-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [IW-1:0]        ram_rd_addr;
   logic [GRID_SIZE-1:0] ram_rd_data;
   logic [GRID_SIZE-1:0] row_data;
   logic [GRID_SIZE-1:0] cell_mask;
   logic [GRID_SIZE-1:0] below;
   logic [GRID_SIZE-1:0] next_row;
   logic [CW-1:0]        wr_cnt;

   tlg_ram #(
      .WIDTH (GRID_SIZE),
      .DEPTH (GRID_SIZE)
   ) u_rows (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // a row never written since reset reads dead
   assign row_data  = valid_ff[rd_addr_ff] ? ram_rd_data : '0;
   assign cell_mask = {{(GRID_SIZE-1){1'b0}}, 1'b1} << col_ff;
   assign below     = (cnt_ff == CNT_LAST) ? row0_ff : row_data;
   assign wr_cnt    = cnt_ff - CW'(2);

   tlg_row_rule #(
      .GRID_SIZE (GRID_SIZE)
   ) u_rule (
      .above    (above_ff),
      .mid      (mid_ff),
      .below    (below),
      .next_row (next_row)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      val_in       = val_ff;
      inside_in    = inside_ff;
      above_in     = above_ff;
      mid_in       = mid_ff;
      row0_in      = row0_ff;
      rd_addr_in   = rd_addr_ff;
      valid_in     = valid_ff;
      res_read_in  = res_read_ff;
      res_kind_in  = res_kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_read_in  = rsp_read_ff;
      rsp_kind_in  = rsp_kind_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = next_row;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in     = req_op;
               row_in    = req_row[IW-1:0];
               col_in    = req_col[IW-1:0];
               val_in    = req_val;
               inside_in = req_inside;
               unique case (req_op) inside
                  OP_WRITE, OP_READ: begin
                     ram_rd_en   = req_inside;
                     ram_rd_addr = req_row[IW-1:0];
                     state_in    = ST_CELL;
                  end
                  OP_STEP: begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = ROW_TOP;
                     cnt_in      = '0;
                     state_in    = ST_STEP;
                  end
                  default: begin
                     // unused opcode: echo only
                     res_read_in = 1'b0;
                     res_kind_in = req_op;
                     state_in    = ST_DONE;
                  end
               endcase
            end
         end

         ST_CELL: begin
            res_kind_in = op_ff;
            res_read_in = inside_ff && (op_ff == OP_READ) && row_data[col_ff];
            if (inside_ff && (op_ff == OP_WRITE)) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = row_ff;
               ram_wr_data = val_ff ? (row_data | cell_mask) : (row_data & ~cell_mask);
            end
            state_in = ST_DONE;
         end

         ST_STEP: begin
            // read row cnt, take in the row read last cycle
            if (cnt_ff < CNT_ROWS) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = cnt_ff[IW-1:0];
            end
            if (cnt_ff == '0) begin
               above_in = row_data;
            end else if (cnt_ff == CW'(1)) begin
               mid_in  = row_data;
               row0_in = row_data;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = wr_cnt[IW-1:0];
               above_in    = mid_ff;
               mid_in      = row_data;
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CNT_LAST) begin
               res_read_in = 1'b0;
               res_kind_in = OP_STEP;
               state_in    = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_read_in  = res_read_ff;
               rsp_kind_in  = res_kind_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (ram_rd_en) begin
         rd_addr_in = ram_rd_addr;
      end
      if (ram_wr_en) begin
         valid_in[ram_wr_addr] = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      op_ff       <= op_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      val_ff      <= val_in;
      inside_ff   <= inside_in;
      above_ff    <= above_in;
      mid_ff      <= mid_in;
      row0_ff     <= row0_in;
      rd_addr_ff  <= rd_addr_in;
      res_read_ff <= res_read_in;
      res_kind_ff <= res_kind_in;
      rsp_read_ff <= rsp_read_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_D_W-1){1'b0}}, rsp_read_ff};
   assign rsp_tuser  = rsp_kind_ff;

endmodule

// ===== sv/tlg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlg_checker
// Port-level checks on the life core, bound to its top level.
// ----------------------------------------------------------------------------
`include "toroidal_life_generation_step_core_assert.svh"

module tlg_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic [tlg_pkg::OP_W-1:0]     req_tuser,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [tlg_pkg::RSP_D_W-1:0]  rsp_tdata,
   input logic [tlg_pkg::OP_W-1:0]     rsp_tuser
);
   import tlg_pkg::*;

   logic       req_fire;
   logic       rsp_fire;
   logic [1:0] pend_ff, pend_in;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // beats accepted but not yet answered
   always_comb begin
      pend_in = pend_ff + {1'b0, req_fire} - {1'b0, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `TLG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `TLG_ASSERT_NOW(a_read_only, clock, reset, rsp_tvalid && (rsp_tuser != OP_READ), !rsp_tdata[0])
   `TLG_ASSERT_NOW(a_no_orphan, clock, reset, rsp_fire, pend_ff != 2'd0)
   `TLG_ASSERT_NEXT(a_step_busy, clock, reset, req_fire && (req_tuser == OP_STEP), !req_tready)

endmodule

bind toroidal_life_generation_step_core tlg_checker u_tlg_checker (.*);
